FILE: sv/rde_pkg.sv
// shared constants for the radix digit emitter
// no dependencies; imported by every rde module except rde_ram
package rde_pkg;

  localparam int MAX_DIGITS = 63;
  localparam int DIGIT_AW   = $clog2(MAX_DIGITS);
  localparam int NUM_W      = 63;
  localparam int WORK_W     = 64;
  localparam int CHUNK_W    = 8;
  localparam int CHUNKS     = WORK_W / CHUNK_W;
  localparam int CHUNK_CW   = $clog2(CHUNKS);
  localparam int DIGIT_W    = 4;
  localparam int RADIX_W    = 5;
  localparam int SYM_W      = 8;
  localparam int COUNT_W    = 6;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_NUMBER_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

endpackage

FILE: sv/rde_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module rde_ram #(
  parameter int Width = 4,
  parameter int Depth = 63
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/rde_div_unit.sv
// shared divide step: eight restoring long-division bits per call
// depends on rde_pkg
module rde_div_unit (
  input  logic [rde_pkg::DIGIT_W-1:0] rem_i,
  input  logic [rde_pkg::CHUNK_W-1:0] chunk_i,
  input  logic [rde_pkg::RADIX_W-1:0] radix_i,
  output logic [rde_pkg::DIGIT_W-1:0] rem_o,
  output logic [rde_pkg::CHUNK_W-1:0] quot_o
);
  import rde_pkg::*;

  always_comb begin
    logic [RADIX_W-1:0] r;
    r      = {1'b0, rem_i};
    quot_o = '0;
    for (int i = CHUNK_W - 1; i >= 0; i--) begin
      // remainder stays below radix, so the shifted value fits five bits
      r = {r[DIGIT_W-1:0], chunk_i[i]};
      if (r >= radix_i) begin
        r         = r - radix_i;
        quot_o[i] = 1'b1;
      end
    end
    rem_o = r[DIGIT_W-1:0];
  end

endmodule

FILE: sv/radix_digit_emitter_top.sv
// radix digit emitter top level: config registers, sequencer, output register
// depends on rde_pkg, rde_div_unit, rde_ram
//
// Usage
//   Input channel (in_valid_i / in_ready_o) takes one beat: a 63-bit
//   non-negative number_in_i. Output channel (out_valid_o / out_ready_i)
//   gives one beat per digit, most significant first, each with symbol_o
//   (ASCII byte from the symbol table), last_digit_o on the final digit and
//   digit_count_o, the total number of digits. Zero gives one digit.
//   The config port writes number_base (index 0, saturated to 2..16 in use),
//   digit_symbols_low (1) and digit_symbols_high (2); index 3 is ignored.
// Timing
//   Each digit takes one pass of the shared divide unit over the 64-bit
//   working word, eight quotient bits a cycle. ST_RD then issues the first
//   ram read and ST_LD loads the output register, after which digits leave
//   at one per cycle while out_ready_i is high; in_ready_o is high only
//   when no item is in work.
// Reset
//   rst_ni clears the sequencer and output valid, base goes to 10 and the
//   symbol table to zero. The digit ram needs no clearing.
// Stall
//   A held-off output beat stays in the output register; the next digit
//   waits in the ram read register until the beat is taken.
module radix_digit_emitter_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [rde_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rde_pkg::CFG_W-1:0]      cfg_wdata_i,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [rde_pkg::NUM_W-1:0]      number_in_i,
  // output channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [rde_pkg::SYM_W-1:0]      symbol_o,
  output logic                           last_digit_o,
  output logic [rde_pkg::COUNT_W-1:0]    digit_count_o
);
  import rde_pkg::*;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_LD   = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  // configuration registers
  logic [RADIX_W-1:0] base_q;
  logic [CFG_W-1:0]   sym_lo_q;
  logic [CFG_W-1:0]   sym_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= RADIX_RESET;
      sym_lo_q <= '0;
      sym_hi_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_NUMBER_BASE:  base_q   <= cfg_wdata_i[RADIX_W-1:0];
        REG_SYMBOLS_LOW:  sym_lo_q <= cfg_wdata_i;
        REG_SYMBOLS_HIGH: sym_hi_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // base saturated into 2..16
  logic [RADIX_W-1:0] radix;
  always_comb begin
    if (base_q < RADIX_MIN) begin
      radix = RADIX_MIN;
    end else if (base_q > RADIX_MAX) begin
      radix = RADIX_MAX;
    end else begin
      radix = base_q;
    end
  end

  // sequencer and datapath state
  logic [2:0]            state_q, state_d;
  logic [WORK_W-1:0]     work_q, work_d;      // dividend shifts out, quotient shifts in
  logic [DIGIT_W-1:0]    rem_q, rem_d;
  logic                  qnz_q, qnz_d;        // quotient has a set bit so far
  logic [CHUNK_CW-1:0]   chunk_q, chunk_d;
  logic [COUNT_W-1:0]    count_q, count_d;    // digits written so far
  logic [DIGIT_AW-1:0]   data_idx_q, data_idx_d; // ram index behind the read register
  logic                  out_valid_q, out_valid_d;
  logic [SYM_W-1:0]      symbol_q, symbol_d;
  logic                  last_q, last_d;

  // shared divide unit
  logic [DIGIT_W-1:0] div_rem;
  logic [CHUNK_W-1:0] div_quot;

  rde_div_unit u_div (
    .rem_i   (rem_q),
    .chunk_i (work_q[WORK_W-1 -: CHUNK_W]),
    .radix_i (radix),
    .rem_o   (div_rem),
    .quot_o  (div_quot)
  );

  // digit store
  logic                ram_we;
  logic                ram_re;
  logic [DIGIT_AW-1:0] ram_raddr;
  logic [DIGIT_W-1:0]  ram_rdata;

  rde_ram #(
    .Width (DIGIT_W),
    .Depth (MAX_DIGITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[DIGIT_AW-1:0]),
    .wdata_i (div_rem),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // symbol table lookup on the digit in the ram read register
  logic [SYM_W-1:0] rd_symbol;
  always_comb begin
    if (ram_rdata[DIGIT_W-1]) begin
      rd_symbol = sym_hi_q[{ram_rdata[DIGIT_W-2:0], 3'b000} +: SYM_W];
    end else begin
      rd_symbol = sym_lo_q[{ram_rdata[DIGIT_W-2:0], 3'b000} +: SYM_W];
    end
  end

  logic [COUNT_W:0] count_inc;
  assign count_inc = {1'b0, count_q} + 1'b1;

  // whole quotient nonzero, including this cycle's byte
  logic qnz_next;
  assign qnz_next = qnz_q | (|div_quot);

  always_comb begin
    state_d     = state_q;
    work_d      = work_q;
    rem_d       = rem_q;
    qnz_d       = qnz_q;
    chunk_d     = chunk_q;
    count_d     = count_q;
    data_idx_d  = data_idx_q;
    out_valid_d = out_valid_q;
    symbol_d    = symbol_q;
    last_d      = last_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = data_idx_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          work_d  = {1'b0, number_in_i};
          rem_d   = '0;
          qnz_d   = 1'b0;
          chunk_d = '0;
          count_d = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        // one byte of long division per cycle
        work_d  = {work_q[WORK_W-CHUNK_W-1:0], div_quot};
        rem_d   = div_rem;
        qnz_d   = qnz_next;
        chunk_d = chunk_q + 1'b1;
        if (chunk_q == CHUNK_CW'(CHUNKS - 1)) begin
          // remainder is the next digit, least significant first
          ram_we  = 1'b1;
          count_d = count_inc[COUNT_W-1:0];
          rem_d   = '0;
          qnz_d   = 1'b0;
          chunk_d = '0;
          if (!(qnz_next && (count_inc < (COUNT_W+1)'(MAX_DIGITS)))) begin
            data_idx_d = count_q[DIGIT_AW-1:0];
            state_d    = ST_RD;
          end
        end
      end
      ST_RD: begin
        ram_re  = 1'b1;
        state_d = ST_LD;
      end
      ST_LD: begin
        out_valid_d = 1'b1;
        symbol_d    = rd_symbol;
        last_d      = (data_idx_q == '0);
        if (data_idx_q != '0) begin
          // prefetch the next lower digit
          ram_re     = 1'b1;
          ram_raddr  = data_idx_q - 1'b1;
          data_idx_d = data_idx_q - 1'b1;
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready_i) begin
          if (last_q) begin
            out_valid_d = 1'b0;
            state_d     = ST_IDLE;
          end else begin
            symbol_d = rd_symbol;
            last_d   = (data_idx_q == '0);
            if (data_idx_q != '0) begin
              ram_re     = 1'b1;
              ram_raddr  = data_idx_q - 1'b1;
              data_idx_d = data_idx_q - 1'b1;
            end
          end
        end
      end
      default: begin
        state_d     = ST_IDLE;
        out_valid_d = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      chunk_q     <= '0;
      count_q     <= '0;
      data_idx_q  <= '0;
      qnz_q       <= 1'b0;
      work_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      chunk_q     <= chunk_d;
      count_q     <= count_d;
      data_idx_q  <= data_idx_d;
      qnz_q       <= qnz_d;
      work_q      <= work_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    symbol_q <= symbol_d;
    last_q   <= last_d;
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign symbol_o      = symbol_q;
  assign last_digit_o  = last_q;
  assign digit_count_o = count_q;

endmodule

FILE: dv/rde_checker.sv
// digit predictor and beat checker for the radix digit emitter
// depends on rde_pkg; instantiated by radix_digit_emitter_top_test
module rde_checker
  import rde_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [NUM_W-1:0]     number_in_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [SYM_W-1:0]     symbol_i,
  input  logic                 last_digit_i,
  input  logic [COUNT_W-1:0]   digit_count_i,
  output int                   mismatch_count_o,
  output int                   digits_owed_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [SYM_W-1:0]   symbol;
    logic               last_digit;
    logic [COUNT_W-1:0] digit_count;
  } digit_beat_t;

  digit_beat_t        owed_digits[$];
  logic [RADIX_W-1:0] base_q;
  logic [CFG_W-1:0]   symbols_lo_q;
  logic [CFG_W-1:0]   symbols_hi_q;

  // divide down by the saturated radix, then queue the digits msd first
  function automatic void expand_number(input logic [NUM_W-1:0] value);
    logic [DIGIT_W-1:0] rem_digits[MAX_DIGITS];
    logic [NUM_W-1:0]   quot;
    logic [NUM_W-1:0]   radix;
    logic [NUM_W-1:0]   rem;
    logic [DIGIT_W-1:0] d;
    int                 n;
    digit_beat_t        beat;
    radix = NUM_W'((base_q < RADIX_MIN) ? RADIX_MIN
                   : (base_q > RADIX_MAX) ? RADIX_MAX : base_q);
    quot  = value;
    n     = 0;
    do begin
      rem           = quot % radix;
      rem_digits[n] = rem[DIGIT_W-1:0];
      quot          = quot / radix;
      n++;
    end while (quot != 0 && n < MAX_DIGITS);
    for (int k = n - 1; k >= 0; k--) begin
      d                = rem_digits[k];
      beat.symbol      = d[3] ? symbols_hi_q[d[2:0]*SYM_W +: SYM_W]
                              : symbols_lo_q[d[2:0]*SYM_W +: SYM_W];
      beat.last_digit  = (k == 0);
      beat.digit_count = n[COUNT_W-1:0];
      owed_digits.push_back(beat);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    int          bad;
    digit_beat_t want;
    if (!rst_ni) begin
      base_q       <= RADIX_RESET;
      symbols_lo_q <= '0;
      symbols_hi_q <= '0;
      owed_digits.delete();
      mismatch_count_o <= 0;
      digits_owed_o    <= 0;
    end else begin
      bad = 0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_NUMBER_BASE:  base_q       <= cfg_wdata_i[RADIX_W-1:0];
          REG_SYMBOLS_LOW:  symbols_lo_q <= cfg_wdata_i;
          REG_SYMBOLS_HIGH: symbols_hi_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      // output first: a beat in this cycle belongs to an earlier number
      if (out_valid_i && out_ready_i) begin
        if (owed_digits.size() == 0) begin
          $error("unexpected digit beat: symbol %0h last %0b count %0d",
                 symbol_i, last_digit_i, digit_count_i);
          bad++;
        end else begin
          want = owed_digits.pop_front();
          if (symbol_i !== want.symbol) begin
            $error("symbol: expected %0h, actual %0h", want.symbol, symbol_i);
            bad++;
          end
          if (last_digit_i !== want.last_digit) begin
            $error("last_digit: expected %0b, actual %0b", want.last_digit, last_digit_i);
            bad++;
          end
          if (digit_count_i !== want.digit_count) begin
            $error("digit_count: expected %0d, actual %0d", want.digit_count, digit_count_i);
            bad++;
          end
        end
      end
      if (in_valid_i && in_ready_i) expand_number(number_in_i);
      mismatch_count_o <= mismatch_count_o + bad;
      digits_owed_o    <= owed_digits.size();
    end
  end

endmodule

FILE: dv/radix_digit_emitter_top_test.sv
// testbench top for the radix digit emitter: clock, reset, stimulus, verdict
// depends on rde_pkg, radix_digit_emitter_top and rde_checker
module radix_digit_emitter_top_test;
  import rde_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TARGET_NUMBERS = 220;
  localparam int CYCLE_LIMIT    = 1_500_000;
  localparam int TAIL_CYCLES    = 20;
  // index past the register list, writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [NUM_W-1:0]     NUM_MAX    = '1;

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx     = '0;
  logic [CFG_W-1:0]     cfg_wdata   = '0;
  logic                 in_valid    = 1'b0;
  logic                 in_ready;
  logic [NUM_W-1:0]     number_in   = '0;
  logic                 out_valid;
  logic                 out_ready   = 1'b0;
  logic [SYM_W-1:0]     symbol;
  logic                 last_digit;
  logic [COUNT_W-1:0]   digit_count;
  int                   mismatch_count;
  int                   digits_owed;
  int                   cycle_count = 0;
  bit                   no_idle     = 1'b0;  // phases with back-to-back beats

  radix_digit_emitter_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .number_in_i   (number_in),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .symbol_o      (symbol),
    .last_digit_o  (last_digit),
    .digit_count_o (digit_count)
  );

  rde_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .number_in_i      (number_in),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .symbol_i         (symbol),
    .last_digit_i     (last_digit),
    .digit_count_i    (digit_count),
    .mismatch_count_o (mismatch_count),
    .digits_owed_o    (digits_owed)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stall before each digit beat, then hold ready until taken
  initial begin
    int stall;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
      @(negedge clk_i);
    end
  end

  // one input beat; entered and left at a falling edge, valid left high so a
  // zero gap keeps it up for the next number without a drop
  task automatic send_number(input logic [NUM_W-1:0] value);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid  <= 1'b1;
    number_in <= value;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
  endtask

  // drop valid and wait until every owed digit has come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (digits_owed != 0) @(negedge clk_i);
  endtask

  // write enable stays high across a group of writes, end_writes drops it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk_i);
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  // reprogram all three registers once the block has gone quiet
  task automatic load_table(input logic [CFG_W-1:0] base_word,
                            input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
    wait_idle();
    write_reg(REG_NUMBER_BASE, base_word);
    write_reg(REG_SYMBOLS_LOW, lo);
    write_reg(REG_SYMBOLS_HIGH, hi);
    end_writes();
  endtask

  initial begin
    int                 sent;
    logic [RADIX_W-1:0] base;
    logic [CFG_W-1:0]   base_word;
    logic [NUM_W-1:0]   radix;
    logic [NUM_W-1:0]   num;

    sent = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset config: base 10, every symbol zero, so only count and last matter
    send_number('0);
    send_number(63'd12345);

    // readable hex table, base 10; a write past the register list must be dropped
    load_table(64'd10, "76543210", "fedcba98");
    write_reg(REG_UNUSED, '1);
    end_writes();
    send_number('0);
    send_number(63'd9);
    send_number(63'd10);
    send_number(63'd1);
    send_number(NUM_MAX);

    // base field 0 with junk above it: saturates to 2, all ones gives 63 digits
    load_table(64'hFFFF_FFFF_FFFF_FFE0, "76543210", "fedcba98");
    send_number(NUM_MAX);
    send_number(63'd1);
    send_number(63'd2);

    // base 1 saturates to 2 as well
    load_table(64'd1, "76543210", "fedcba98");
    send_number(63'd5);
    send_number('0);

    // top of the legal range
    load_table(64'd16, "76543210", "fedcba98");
    send_number(NUM_MAX);
    send_number(63'd15);
    send_number(63'd16);

    // above sixteen saturates down
    load_table(64'd17, "76543210", "fedcba98");
    send_number(63'd255);
    load_table(64'd31, "76543210", "fedcba98");
    send_number(NUM_MAX);

    // plain base 2 and an odd base around its square
    load_table(64'd2, "76543210", "fedcba98");
    send_number(63'd6);
    load_table(64'd9, "76543210", "fedcba98");
    send_number(63'd80);
    send_number(63'd81);

    // random phases: fresh registers each phase, mostly legal bases
    while (sent < TARGET_NUMBERS) begin
      base = RADIX_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                  : $urandom_range(2, 16));
      base_word          = {$urandom, $urandom};
      base_word[4:0]     = base;
      load_table(base_word, {$urandom, $urandom}, {$urandom, $urandom});
      radix   = NUM_W'((base < RADIX_MIN) ? RADIX_MIN : (base > RADIX_MAX) ? RADIX_MAX : base);
      no_idle = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(8, 24)) begin
        case ($urandom_range(0, 9))
          0: num = '0;
          1: num = NUM_MAX;
          2, 3: begin
            // powers of the radix and one below them sit on digit count steps
            num = 63'd1;
            repeat ($urandom_range(1, 62)) if (num <= NUM_MAX / radix) num = num * radix;
            if ($urandom_range(0, 1) == 1) num = num - 63'd1;
          end
          default: num = NUM_W'({$urandom, $urandom} >> $urandom_range(0, 62));
        endcase
        send_number(num);
        sent++;
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/rde_pkg.sv
sv/rde_ram.sv
sv/rde_div_unit.sv
sv/radix_digit_emitter_top.sv
dv/rde_checker.sv
dv/radix_digit_emitter_top_test.sv
